>>> src/iptl_pkg.sv
// Shared types, constants and state encoding for the IPv4 binary trie lookup block.
// No dependencies; every other source file imports this package.
package iptl_pkg;

  // Record store geometry and trie constants.
  localparam int          RECORD_DEPTH_DEF = 262144;
  localparam int          REC_W            = 48;
  localparam int          PTR_W            = 24;
  localparam int          DB_SIZE_W        = 21;
  localparam int          IDX_W            = 18;
  localparam int          IP_W             = 32;
  localparam int          LEVEL_W          = 5;
  localparam int          BOUND_W          = 27;
  localparam logic [PTR_W-1:0]   LEAF_BASE     = 24'd16776960;
  localparam logic [BOUND_W-1:0] RECORD_BYTES  = 27'd6;
  localparam logic [7:0]         CORRUPT_INDEX = 8'd255;
  localparam logic [LEVEL_W-1:0] TOP_BIT       = 5'd31;

  // Item command codes.
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // One input item.
  typedef struct packed {
    logic              cmd;
    logic [IDX_W-1:0]  record_index;
    logic [REC_W-1:0]  record_data;
    logic [IP_W-1:0]   ip_address;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [7:0] country_index;
    logic       corrupt;
  } out_item_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROOT,
    ST_WALK
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_lookup;
    logic write_rec;
    logic rd_en;
    logic use_ptr;
    logic step;
    logic emit_leaf;
    logic emit_corrupt;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic bad_addr;
    logic leaf;
    logic last_level;
  } dp_status_t;

endpackage

>>> src/iptl_ctrl.sv
// Controller state machine for the trie walk: sequences root check and level steps.
// Depends on iptl_pkg for the state enum and the command and status structs.
module iptl_ctrl
  import iptl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       item_cmd,
  input  dp_status_t status,
  output dp_cmd_t    cmd,
  output logic       busy
);

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (item_cmd == CMD_LOOKUP) begin
            cmd.load_lookup = 1'b1;
            state_nxt       = ST_ROOT;
          end else begin
            cmd.write_rec = 1'b1;
          end
        end
      end
      ST_ROOT: begin
        // The root record itself may already lie outside the database.
        if (status.bad_addr) begin
          cmd.emit_corrupt = 1'b1;
          state_nxt        = ST_IDLE;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        cmd.use_ptr = 1'b1;
        if (status.leaf) begin
          cmd.emit_leaf = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (status.last_level || status.bad_addr) begin
          cmd.emit_corrupt = 1'b1;
          state_nxt        = ST_IDLE;
        end else begin
          cmd.rd_en = 1'b1;
          cmd.step  = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

`ifndef SYNTHESIS
  // A new lookup is only loaded from idle, so it always lands in the root state.
  a_load_to_root: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_lookup |=> (state_r == ST_ROOT))
    else $error("lookup load did not reach root state");

  // A walk step never coincides with emitting a result.
  a_step_no_emit: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.step && (cmd.emit_leaf || cmd.emit_corrupt)))
    else $error("walk step and result emitted together");
`endif

endmodule

>>> src/iptl_dp.sv
// Datapath of the trie lookup: record store, walk registers, bound check and result register.
// Depends on iptl_pkg for item types, constants and the command and status structs.
module iptl_dp
  import iptl_pkg::*;
#(
  parameter int RECORD_DEPTH = RECORD_DEPTH_DEF
)(
  input  logic                 clk,
  input  logic                 rst_n,
  input  in_item_t             in_item,
  input  logic                 cfg_we,
  input  logic [DB_SIZE_W-1:0] cfg_wdata,
  input  dp_cmd_t              cmd,
  output dp_status_t           status,
  output logic                 out_valid,
  output out_item_t            out_item
);

  localparam int AW = (RECORD_DEPTH > 1) ? $clog2(RECORD_DEPTH) : 1;
  localparam logic [PTR_W:0] DEPTH_W = (PTR_W + 1)'(RECORD_DEPTH);

  logic [REC_W-1:0]     mem [RECORD_DEPTH];
  logic [REC_W-1:0]     rd_data_r;
  logic [DB_SIZE_W-1:0] db_size_r;
  logic [IP_W-1:0]      ip_r;
  logic [LEVEL_W-1:0]   level_r;
  logic                 out_valid_r;
  out_item_t            out_item_r;

  logic [PTR_W-1:0]     ptr;
  logic [PTR_W-1:0]     chk_x;
  logic [BOUND_W-1:0]   rec_end;
  logic                 wr_ok;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      db_size_r <= '0;
    end else if (cfg_we) begin
      db_size_r <= cfg_wdata;
    end
  end

  // Record store: one write port for write items, one registered read port for the walk.
  assign wr_ok = ({{(PTR_W + 1 - IDX_W){1'b0}}, in_item.record_index} < DEPTH_W);

  always_ff @(posedge clk) begin
    if (cmd.write_rec && wr_ok) begin
      mem[AW'(in_item.record_index)] <= in_item.record_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r <= mem[AW'(chk_x)];
    end
  end

  // The address bit for this level picks the right or the left pointer.
  assign ptr = ip_r[level_r] ? rd_data_r[2*PTR_W-1:PTR_W] : rd_data_r[PTR_W-1:0];

  // Bound check on the record about to be read: the root, or the pointer just taken.
  assign chk_x   = cmd.use_ptr ? ptr : '0;
  assign rec_end = {1'b0, chk_x, 2'b00} + {2'b00, chk_x, 1'b0} + RECORD_BYTES;

  assign status.bad_addr   = (rec_end >= {{(BOUND_W - DB_SIZE_W){1'b0}}, db_size_r}) ||
                             ({1'b0, chk_x} >= DEPTH_W);
  assign status.leaf       = (ptr >= LEAF_BASE);
  assign status.last_level = (level_r == '0);

  // Walk registers: the address and the level that is tested next.
  always_ff @(posedge clk) begin
    if (cmd.load_lookup) begin
      ip_r    <= in_item.ip_address;
      level_r <= TOP_BIT;
    end else if (cmd.step) begin
      level_r <= level_r - 1'b1;
    end
  end

  // Result register, shown for exactly one cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_leaf || cmd.emit_corrupt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_leaf) begin
      out_item_r.country_index <= 8'(ptr - LEAF_BASE);
      out_item_r.corrupt       <= 1'b0;
    end else if (cmd.emit_corrupt) begin
      out_item_r.country_index <= CORRUPT_INDEX;
      out_item_r.corrupt       <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTHESIS
  // Each lookup emits its result only once, on its way back to idle, so the result strobe is never held.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for two cycles");

  // A corrupt result always carries the corruption index.
  a_corrupt_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.corrupt) |-> (out_item_r.country_index == CORRUPT_INDEX))
    else $error("corrupt result with wrong index");

  // A level step is only taken while levels remain.
  a_step_level: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (level_r != '0))
    else $error("walk stepped past the last level");
`endif

endmodule

>>> src/ipv4_binary_trie_lookup.sv
// Top level of the IPv4 binary trie lookup block: joins the controller and the datapath.
// Depends on iptl_pkg, iptl_ctrl and iptl_dp.
//
// Usage:
//   Input channel: an item is taken at a rising edge with start high and busy low.
//   A write item (cmd = 0) stores record_data at record_index in the same edge if
//   record_index is below RECORD_DEPTH, and gives no result; busy stays low, so another
//   item may follow in the next cycle. A lookup item (cmd = 1) walks the trie from
//   record 0, testing address bit 31 first. Each level reads one record through the
//   single registered read port of the record store: busy is high for the root check
//   and while the walk reads k records (0 to 32), and the result strobe out_valid rises
//   in the same cycle as busy falls. A new item may be accepted in the cycle the result
//   is shown.
//   Result channel: out_valid marks out_item for exactly one cycle; the receiver
//   cannot stall it, and results are never held back.
//   Configuration: cfg_we writes db_size_bytes from cfg_wdata; write it only while idle.
//   Reset (rst_n low, synchronous) returns the controller to idle, clears the strobe
//   and sets db_size_bytes to 0. The record store is not cleared; load every record a
//   lookup may reach before looking up.
module ipv4_binary_trie_lookup
  import iptl_pkg::*;
#(
  parameter int RECORD_DEPTH = RECORD_DEPTH_DEF
)(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_item,
  output logic                 out_valid,
  output out_item_t            out_item,
  input  logic                 cfg_we,
  input  logic [DB_SIZE_W-1:0] cfg_wdata
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Controller.
  iptl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .item_cmd (in_item.cmd),
    .status   (status),
    .cmd      (cmd),
    .busy     (busy)
  );

  // Datapath.
  iptl_dp #(
    .RECORD_DEPTH (RECORD_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
